/* hw/rtl/sfla_pkg.sv */
package sfla_pkg;

  localparam int ADDR_W       = 16;
  localparam int ALIGN_BYTES  = 8;
  localparam int ALIGN_SH     = 3;
  localparam int LINK_SLOTS   = 8192;
  localparam int SLOT_W       = 13;
  localparam int GROW_SHIFT   = 4;
  localparam int CNT_W        = 7;
  localparam int PW           = 17;
  localparam int REFILL_RESET = 20;
  localparam int HLIM_RESET   = 65536;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_REALLOC = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BIG = 2'd1,
    ST_OOM = 2'd2
  } status_t;

  localparam logic REG_REFILL = 1'b0;
  localparam logic REG_HLIMIT = 1'b1;

  localparam logic [1:0] PASS_LAST = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FREE,
    S_HEAD,
    S_POP,
    S_MUL,
    S_CHECK,
    S_GROWC,
    S_REM,
    S_GROW,
    S_SCAN,
    S_SPOP,
    S_CARVE,
    S_LINK,
    S_DONE
  } state_t;

endpackage

/* hw/rtl/sfla_ram.sv */
module sfla_ram
  import sfla_pkg::*;
#(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/segregated_free_list_allocator.sv */
// A free runs S_FREE, S_DONE; an allocation from a non-empty list S_HEAD, S_POP,
//   S_DONE; a refill S_MUL, S_CHECK, S_CARVE and one S_LINK per block linked, each
//   pool pass S_GROWC, S_REM (if a remnant), S_GROW; scavenging one S_SCAN per head.
//   One transaction at a time, busy meanwhile.
// The result strobe is high for one cycle; the receiver cannot stall.
// Reset (synchronous, rst_n low) empties all lists and the pool and rewinds the heap;
//   the link memory is not cleared.
module segregated_free_list_allocator
  import sfla_pkg::*;
#(
  parameter int HEAP_BYTES = 65536,
  parameter int MAX_SMALL  = 128,
  parameter int NUM_LISTS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_req_type,
  input  logic [15:0]       in_block_addr,
  input  logic [15:0]       in_size_bytes,
  input  logic [15:0]       in_new_size_bytes,
  output logic              out_valid,
  output logic [15:0]       out_result_addr,
  output logic [1:0]        out_status,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int SMALL    = (MAX_SMALL < NUM_LISTS * ALIGN_BYTES) ? MAX_SMALL
                                                                  : NUM_LISTS * ALIGN_BYTES;
  localparam int LAST_CLS = SMALL / ALIGN_BYTES - 1;
  localparam int CLS_W    = $clog2(NUM_LISTS);
  localparam int SCAV_W   = CLS_W + 1;
  localparam int SIZE_W   = $clog2(SMALL + 1);
  localparam int TOT_W    = SIZE_W + CNT_W;
  localparam int GROW_W   = TOT_W + 2;
  localparam int EW       = ((GROW_W > PW) ? GROW_W : PW) + 2;
  localparam logic [PW-1:0] HEAP_LIM = PW'(HEAP_BYTES);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  refill_r, refill_nxt;
  logic [PW-1:0]     hlim_r, hlim_nxt;
  logic [ADDR_W-1:0] heads_r [NUM_LISTS];
  logic [PW-1:0]     pstart_r, pstart_nxt, pend_r, pend_nxt;
  logic [PW-1:0]     htop_r, htop_nxt, hgrown_r, hgrown_nxt;
  logic [1:0]        pass_r, pass_nxt;
  logic [SCAV_W-1:0] scav_r, scav_nxt;

  logic [1:0]        req_r, req_nxt;
  logic [ADDR_W-1:0] blk_r, blk_nxt;
  logic [CLS_W-1:0]  cls_a_r, cls_a_nxt, cls_b_r, cls_b_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, i_r, i_nxt;
  logic [TOT_W-1:0]  tot_r, tot_nxt;
  logic [GROW_W-1:0] grow_r, grow_nxt;
  logic [PW-1:0]     cur_r, cur_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt, res_r, res_nxt;
  logic [1:0]        stat_r, stat_nxt;

  logic              hw_en;
  logic [CLS_W-1:0]  hw_idx, head_idx;
  logic [ADDR_W-1:0] hw_data, head_rd;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  logic [ADDR_W-1:0] ram_wdata, ram_rdata;

  function automatic logic cls_ok(input logic [15:0] bytes);
    return (bytes == 16'd0) || (32'(bytes) <= SMALL);
  endfunction

  function automatic logic [CLS_W-1:0] cls_of(input logic [15:0] bytes);
    logic [15:0] m1;
    m1 = (bytes == 16'd0) ? 16'd0 : bytes - 16'd1;
    return CLS_W'(m1 >> ALIGN_SH);
  endfunction

  logic              a_ok, b_ok;
  logic [SIZE_W-1:0] size_w;
  logic [PW-1:0]     left, lim;
  logic [EW-1:0]     cs1, cs2, rnd;
  logic              fit, rem_nz, grow_ok, scav_end, p_nz, blk_ok, nxt_ok, pass_end;
  logic [CLS_W-1:0]  rem_cls;
  logic              cfg_wr;

  assign a_ok     = cls_ok(in_size_bytes);
  assign b_ok     = cls_ok(in_req_type == REQ_ALLOC ? in_size_bytes : in_new_size_bytes);
  assign size_w   = SIZE_W'({(SCAV_W'(cls_b_r) + SCAV_W'(1)), 3'b000});
  assign left     = pend_r - pstart_r;
  assign lim      = (hlim_r < HEAP_LIM) ? hlim_r : HEAP_LIM;
  assign cs1      = EW'(cur_r) + EW'(size_w);
  assign cs2      = cs1 + EW'(size_w);
  assign rnd      = ((EW'(hgrown_r >> GROW_SHIFT) + EW'(7)) >> ALIGN_SH) << ALIGN_SH;
  assign fit      = left >= PW'(size_w);
  assign rem_nz   = left != '0;
  assign rem_cls  = CLS_W'((left - PW'(1)) >> ALIGN_SH);
  assign grow_ok  = (htop_r <= lim) && (EW'(grow_r) <= EW'(lim) - EW'(htop_r));
  assign scav_end = 32'(scav_r) > LAST_CLS;
  assign p_nz     = head_rd != '0;
  assign blk_ok   = (i_r < cnt_r) && (cs1 <= EW'(pend_r));
  assign nxt_ok   = ((CNT_W + 1)'(i_r) + (CNT_W + 1)'(1) < (CNT_W + 1)'(cnt_r)) &&
                    (cs2 <= EW'(pend_r));
  assign pass_end = pass_r == PASS_LAST;
  assign head_rd  = heads_r[head_idx];

  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_HLIMIT) ? 32'(hlim_r) : 32'(refill_r);

  always_comb begin
    refill_nxt = refill_r;
    hlim_nxt   = hlim_r;
    if (cfg_wr) begin
      if (paddr[2] == REG_REFILL) begin
        refill_nxt = pwdata[CNT_W-1:0];
      end else begin
        hlim_nxt = pwdata[PW-1:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_req_type)
            REQ_ALLOC:   state_nxt = a_ok ? S_HEAD : S_DONE;
            REQ_FREE:    state_nxt = (a_ok && in_block_addr != '0) ? S_FREE : S_DONE;
            REQ_REALLOC: state_nxt = !(a_ok && b_ok) ? S_DONE :
                                     (in_block_addr != '0) ? S_FREE : S_HEAD;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_FREE:  state_nxt = (req_r == REQ_REALLOC) ? S_HEAD : S_DONE;
      S_HEAD:  state_nxt = p_nz ? S_POP : S_MUL;
      S_POP:   state_nxt = S_DONE;
      S_MUL:   state_nxt = S_CHECK;
      S_CHECK: state_nxt = fit ? S_CARVE : S_GROWC;
      S_GROWC: state_nxt = rem_nz ? S_REM : S_GROW;
      S_REM:   state_nxt = S_GROW;
      S_GROW:  state_nxt = !grow_ok ? S_SCAN : pass_end ? S_DONE : S_CHECK;
      S_SCAN:  state_nxt = scav_end ? S_DONE : p_nz ? S_SPOP : S_SCAN;
      S_SPOP:  state_nxt = pass_end ? S_DONE : S_CHECK;
      S_CARVE: state_nxt = blk_ok ? S_LINK : S_DONE;
      S_LINK:  state_nxt = nxt_ok ? S_LINK : S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    pstart_nxt = pstart_r;
    pend_nxt   = pend_r;
    htop_nxt   = htop_r;
    hgrown_nxt = hgrown_r;
    pass_nxt   = pass_r;
    scav_nxt   = scav_r;
    req_nxt    = req_r;
    blk_nxt    = blk_r;
    cls_a_nxt  = cls_a_r;
    cls_b_nxt  = cls_b_r;
    cnt_nxt    = cnt_r;
    i_nxt      = i_r;
    tot_nxt    = tot_r;
    grow_nxt   = grow_r;
    cur_nxt    = cur_r;
    base_nxt   = base_r;
    res_nxt    = res_r;
    stat_nxt   = stat_r;
    hw_en      = 1'b0;
    hw_idx     = cls_b_r;
    hw_data    = head_rd;
    head_idx   = cls_b_r;
    ram_we     = 1'b0;
    ram_waddr  = blk_r[ADDR_W-1:ALIGN_SH];
    ram_wdata  = head_rd;
    ram_raddr  = head_rd[ADDR_W-1:ALIGN_SH];
    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req_type;
          blk_nxt   = in_block_addr;
          cls_a_nxt = cls_of(in_size_bytes);
          cls_b_nxt = cls_of(in_req_type == REQ_ALLOC ? in_size_bytes : in_new_size_bytes);
          res_nxt   = '0;
          stat_nxt  = ST_OK;
          if ((in_req_type == REQ_ALLOC || in_req_type == REQ_FREE) && !a_ok) begin
            stat_nxt = ST_BIG;
          end
          if (in_req_type == REQ_REALLOC && !(a_ok && b_ok)) begin
            stat_nxt = ST_BIG;
          end
        end
      end
      S_FREE: begin
        head_idx  = cls_a_r;
        ram_we    = 1'b1;
        hw_en     = 1'b1;
        hw_idx    = cls_a_r;
        hw_data   = blk_r;
      end
      S_HEAD: begin
        base_nxt = head_rd;
        cnt_nxt  = (refill_r == '0) ? CNT_W'(1) : refill_r;
        pass_nxt = '0;
      end
      S_POP: begin
        hw_en   = 1'b1;
        hw_data = ram_rdata;
        res_nxt = base_r;
      end
      S_MUL: begin
        tot_nxt = TOT_W'(size_w) * TOT_W'(cnt_r);
      end
      S_CHECK: begin
        base_nxt = pstart_r[ADDR_W-1:0];
        cur_nxt  = pstart_r + PW'(size_w);
        i_nxt    = CNT_W'(1);
      end
      S_GROWC: begin
        grow_nxt = GROW_W'({tot_r, 1'b0}) + GROW_W'(rnd);
      end
      S_REM: begin
        head_idx  = rem_cls;
        ram_we    = 1'b1;
        ram_waddr = pstart_r[ADDR_W-1:ALIGN_SH];
        hw_en     = 1'b1;
        hw_idx    = rem_cls;
        hw_data   = pstart_r[ADDR_W-1:0];
      end
      S_GROW: begin
        pstart_nxt = '0;
        pend_nxt   = '0;
        scav_nxt   = SCAV_W'(cls_b_r);
        if (grow_ok) begin
          pstart_nxt = htop_r;
          pend_nxt   = htop_r + PW'(grow_r);
          htop_nxt   = htop_r + PW'(grow_r);
          hgrown_nxt = hgrown_r + PW'(grow_r);
          pass_nxt   = pass_r + 2'd1;
          if (pass_end) begin
            stat_nxt = ST_OOM;
          end
        end
      end
      S_SCAN: begin
        head_idx = scav_r[CLS_W-1:0];
        if (scav_end) begin
          stat_nxt = ST_OOM;
        end else if (p_nz) begin
          pstart_nxt = PW'(head_rd);
          pend_nxt   = PW'(head_rd) + PW'({(scav_r + SCAV_W'(1)), 3'b000});
        end else begin
          scav_nxt = scav_r + SCAV_W'(1);
        end
      end
      S_SPOP: begin
        hw_en    = 1'b1;
        hw_idx   = scav_r[CLS_W-1:0];
        hw_data  = ram_rdata;
        pass_nxt = pass_r + 2'd1;
        if (pass_end) begin
          stat_nxt = ST_OOM;
        end
      end
      S_CARVE: begin
        if (blk_ok) begin
          hw_en   = 1'b1;
          hw_data = cur_r[ADDR_W-1:0];
        end else begin
          pstart_nxt = cur_r;
          res_nxt    = base_r;
        end
      end
      S_LINK: begin
        ram_we    = 1'b1;
        ram_waddr = cur_r[ADDR_W-1:ALIGN_SH];
        ram_wdata = nxt_ok ? cs1[ADDR_W-1:0] : '0;
        if (nxt_ok) begin
          cur_nxt = PW'(cs1);
          i_nxt   = i_r + CNT_W'(1);
        end else begin
          pstart_nxt = PW'(cs1);
          res_nxt    = base_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy            = state_r != S_IDLE;
  assign out_valid       = state_r == S_DONE;
  assign out_result_addr = res_r;
  assign out_status      = stat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      refill_r <= CNT_W'(REFILL_RESET);
      hlim_r   <= PW'(HLIM_RESET);
      pstart_r <= '0;
      pend_r   <= '0;
      htop_r   <= PW'(ALIGN_BYTES);
      hgrown_r <= '0;
      pass_r   <= '0;
      scav_r   <= '0;
      for (int k = 0; k < NUM_LISTS; k++) begin
        heads_r[k] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      refill_r <= refill_nxt;
      hlim_r   <= hlim_nxt;
      pstart_r <= pstart_nxt;
      pend_r   <= pend_nxt;
      htop_r   <= htop_nxt;
      hgrown_r <= hgrown_nxt;
      pass_r   <= pass_nxt;
      scav_r   <= scav_nxt;
      if (hw_en) begin
        heads_r[hw_idx] <= hw_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    blk_r   <= blk_nxt;
    cls_a_r <= cls_a_nxt;
    cls_b_r <= cls_b_nxt;
    cnt_r   <= cnt_nxt;
    i_r     <= i_nxt;
    tot_r   <= tot_nxt;
    grow_r  <= grow_nxt;
    cur_r   <= cur_nxt;
    base_r  <= base_nxt;
    res_r   <= res_nxt;
    stat_r  <= stat_nxt;
  end

  sfla_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (LINK_SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef ASSERT_OFF
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result_addr == '0)
    else $error("failed transaction returned an address");

  a_pool_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK |-> pstart_r <= pend_r)
    else $error("pool start beyond pool end");
`endif

endmodule

/* verif/tb_segregated_free_list_allocator.sv */
`timescale 1ns / 1ps
module tb_segregated_free_list_allocator;
  import sfla_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_req_type = 2'd0;
  logic [15:0] in_block_addr = '0;
  logic [15:0] in_size_bytes = '0;
  logic [15:0] in_new_size_bytes = '0;
  logic        out_valid;
  logic [15:0] out_result_addr;
  logic [1:0]  out_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  segregated_free_list_allocator uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_block_addr(in_block_addr),
    .in_size_bytes(in_size_bytes), .in_new_size_bytes(in_new_size_bytes),
    .out_valid(out_valid), .out_result_addr(out_result_addr), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  typedef struct packed {
    logic [15:0] addr;
    status_t     status;
  } grant_t;

  typedef struct {
    logic [1:0]  req;
    logic [15:0] addr;
    logic [15:0] sz;
    logic [15:0] nsz;
    bit          fixed;
    logic [15:0] exp_addr;
    status_t     exp_status;
  } row_t;

  // shadow allocator state
  logic [15:0] heads [16];
  logic [15:0] links [8192];
  int unsigned pstart, pend, htop, hgrown, refill, hlimit;

  grant_t      pending [$];
  int          errors = 0;
  int          n_ok = 0, n_big = 0, n_oom = 0;
  int unsigned cycles = 0;
  int          sender_idle = 24;
  // addresses owned by the stimulus, per class
  logic [15:0] owned [16][$];

  function automatic bit size_class(input int unsigned b, output int unsigned c);
    if (b == 0) b = ALIGN_BYTES;
    if (b > 128) return 0;
    c = (b + 7) / 8 - 1;
    return 1;
  endfunction

  function automatic void push_free(input int unsigned c, input int unsigned a);
    links[(a / 8) % 8192] = heads[c];
    heads[c] = a[15:0];
  endfunction

  function automatic bit carve(input int unsigned size, inout int unsigned cnt,
                               output int unsigned a);
    int unsigned total, left, grow, lim;
    bit found;
    for (int pass = 0; pass < 3; pass++) begin
      total = size * cnt;
      left = pend - pstart;
      if (left >= total || left >= size) begin
        if (left < total) cnt = left / size;
        a = pstart;
        pstart += size * cnt;
        return 1;
      end
      grow = 2 * total + (((hgrown >> GROW_SHIFT) + 7) / 8) * 8;
      if (left > 0) push_free((left + 7) / 8 - 1, pstart);
      pstart = 0;
      pend = 0;
      lim = hlimit < 65536 ? hlimit : 65536;
      if (htop <= lim && grow <= lim - htop) begin
        pstart = htop;
        pend = htop + grow;
        htop += grow;
        hgrown += grow;
        continue;
      end
      found = 0;
      for (int unsigned c = size / 8 - 1; c < 16; c++) begin
        if (heads[c] != 0) begin
          pstart = heads[c];
          heads[c] = links[(pstart / 8) % 8192];
          pend = pstart + (c + 1) * 8;
          found = 1;
          break;
        end
      end
      if (!found) return 0;
    end
    return 0;
  endfunction

  function automatic grant_t allocate(input int unsigned c);
    grant_t g;
    int unsigned size, cnt, a;
    size = (c + 1) * 8;
    g.status = ST_OK;
    g.addr = '0;
    if (heads[c] != 0) begin
      g.addr = heads[c];
      heads[c] = links[(heads[c] / 8) % 8192];
      return g;
    end
    cnt = refill == 0 ? 1 : refill;
    if (!carve(size, cnt, a)) begin
      g.status = ST_OOM;
      return g;
    end
    if (cnt > 1) begin
      heads[c] = 16'((a + size) & 16'hFFFF);
      for (int unsigned i = 1; i < cnt; i++)
        links[((a + i * size) / 8) % 8192] =
            (i == cnt - 1) ? 16'd0 : 16'((a + (i + 1) * size) & 16'hFFFF);
    end
    g.addr = a[15:0];
    return g;
  endfunction

  function automatic grant_t serve(input logic [1:0] req, input logic [15:0] a,
                                   input logic [15:0] sz, input logic [15:0] nsz);
    grant_t g;
    int unsigned c1, c2;
    g = '{addr: '0, status: ST_OK};
    case (req)
      REQ_ALLOC: begin
        if (size_class(sz, c1)) g = allocate(c1);
        else g.status = ST_BIG;
      end
      REQ_FREE: begin
        if (!size_class(sz, c1)) g.status = ST_BIG;
        else if (a != 0) push_free(c1, a);
      end
      REQ_REALLOC: begin
        if (!size_class(sz, c1) || !size_class(nsz, c2)) g.status = ST_BIG;
        else begin
          if (a != 0) push_free(c1, a);
          g = allocate(c2);
        end
      end
      default: ;
    endcase
    return g;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("segregated_free_list_allocator: mismatch");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (pending.size() == 0) begin
        $error("unexpected transaction addr=%h status=%0d", out_result_addr, out_status);
        errors++;
      end else begin
        grant_t g;
        g = pending.pop_front();
        if (out_result_addr !== g.addr) begin
          $error("result_addr expected %h actual %h", g.addr, out_result_addr);
          errors++;
        end
        if (out_status !== g.status) begin
          $error("status expected %0d actual %0d", g.status, out_status);
          errors++;
        end
      end
    end
  end

  task automatic cfg_write(input logic [2:0] a, input logic [31:0] d);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == 3'd0) refill = d & 32'h7F;
    else hlimit = d & 32'h1FFFF;
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // start is held across back-to-back transactions; dropped only for idles and settling
  task automatic issue(input row_t r);
    grant_t g;
    while ($urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= r.req; in_block_addr <= r.addr;
    in_size_bytes <= r.sz; in_new_size_bytes <= r.nsz;
    @(posedge clk);
    while (busy) @(posedge clk);
    g = serve(r.req, r.addr, r.sz, r.nsz);
    if (r.fixed && (g.addr !== r.exp_addr || g.status !== r.exp_status)) begin
      $error("predictor row: expected %h/%0d got %h/%0d", r.exp_addr, r.exp_status,
             g.addr, g.status);
      errors++;
    end
    pending.push_back(g);
    case (g.status)
      ST_OK: n_ok++;
      ST_BIG: n_big++;
      default: n_oom++;
    endcase
    if (g.status == ST_OK && g.addr != 0) begin
      int unsigned c;
      void'(size_class(r.req == REQ_REALLOC ? r.nsz : r.sz, c));
      owned[c].push_back(g.addr);
    end
  endtask

  function automatic row_t mk(input logic [1:0] q, input logic [15:0] a,
                              input logic [15:0] s, input logic [15:0] n);
    return '{req: q, addr: a, sz: s, nsz: n, fixed: 0, exp_addr: '0, exp_status: ST_OK};
  endfunction

  function automatic row_t mkx(input logic [1:0] q, input logic [15:0] a,
                               input logic [15:0] s, input logic [15:0] n,
                               input logic [15:0] ea, input status_t es);
    return '{req: q, addr: a, sz: s, nsz: n, fixed: 1, exp_addr: ea, exp_status: es};
  endfunction

  task automatic random_item();
    row_t r;
    int unsigned c, k, sel;
    sel = $urandom_range(99);
    c = $urandom_range(15);
    r = mk(REQ_ALLOC, 16'($urandom), 16'((c + 1) * 8 - $urandom_range(7)), 16'($urandom));
    if (sel < 45) begin
      r.req = REQ_ALLOC;
    end else if (sel < 75 && owned[c].size() > 0) begin
      k = $urandom_range(owned[c].size() - 1);
      r.req = REQ_FREE;
      r.addr = owned[c][k];
      owned[c].delete(k);
    end else if (sel < 88 && owned[c].size() > 0) begin
      k = $urandom_range(owned[c].size() - 1);
      r.req = REQ_REALLOC;
      r.addr = owned[c][k];
      owned[c].delete(k);
      r.nsz = 16'($urandom_range(128));
    end else if (sel < 94) begin
      r.req = 2'($urandom_range(3));
      r.sz = 16'($urandom);
      r.nsz = 16'($urandom);
      if (r.req == REQ_FREE || r.req == REQ_REALLOC) r.addr = 16'h0000;
      if ($urandom_range(1)) r.sz = 16'd129 + 16'($urandom_range(65406));
    end else begin
      r.req = $urandom_range(1) ? 2'd3 : REQ_ALLOC;
      r.sz = 16'($urandom);
    end
    issue(r);
  endtask

  row_t dir [$];

  initial begin
    foreach (heads[i]) heads[i] = '0;
    foreach (links[i]) links[i] = '0;
    pstart = 0; pend = 0; htop = 8; hgrown = 0;
    refill = REFILL_RESET; hlimit = HLIM_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir.push_back(mkx(REQ_ALLOC, 16'h0000, 16'd0, 16'd0, 16'd8, ST_OK));
    dir.push_back(mkx(REQ_ALLOC, 16'h0000, 16'd8, 16'd0, 16'd16, ST_OK));
    dir.push_back(mkx(REQ_ALLOC, 16'hFFFF, 16'd129, 16'd0, 16'd0, ST_BIG));
    dir.push_back(mkx(REQ_ALLOC, 16'h0000, 16'hFFFF, 16'hFFFF, 16'd0, ST_BIG));
    dir.push_back(mkx(REQ_FREE, 16'd8, 16'd8, 16'd0, 16'd0, ST_OK));
    dir.push_back(mkx(REQ_FREE, 16'd0, 16'd8, 16'd0, 16'd0, ST_OK));
    dir.push_back(mkx(REQ_FREE, 16'd8, 16'hFFFF, 16'd0, 16'd0, ST_BIG));
    dir.push_back(mkx(REQ_ALLOC, 16'h0000, 16'd1, 16'd0, 16'd8, ST_OK));
    dir.push_back(mkx(REQ_REALLOC, 16'd8, 16'd8, 16'd200, 16'd0, ST_BIG));
    dir.push_back(mkx(REQ_REALLOC, 16'd8, 16'd300, 16'd8, 16'd0, ST_BIG));
    dir.push_back(mkx(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, ST_OK));
    dir.push_back(mk(REQ_ALLOC, 16'h0000, 16'd128, 16'd0));
    dir.push_back(mk(REQ_ALLOC, 16'h0000, 16'd127, 16'd0));
    dir.push_back(mk(REQ_REALLOC, 16'd8, 16'd8, 16'd64));
    dir.push_back(mk(REQ_REALLOC, 16'd0, 16'd16, 16'd0));
    dir.push_back(mk(REQ_FREE, 16'hFFFF, 16'd128, 16'h5555));
    dir.push_back(mk(REQ_FREE, 16'h8003, 16'd40, 16'hAAAA));
    foreach (dir[i]) issue(dir[i]);
    settle();

    // tiny refill, small heap, then heap exhaustion with scavenging
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin cfg_write(3'd0, 32'd0); cfg_write(3'd4, 32'd65536); end
        1: begin cfg_write(3'd0, 32'd64); cfg_write(3'd4, 32'd8); end
        2: begin cfg_write(3'd0, 32'd3); cfg_write(3'd4, 32'd4096); end
        3: begin cfg_write(3'd0, 32'd1); cfg_write(3'd4, 32'h1FFFF); end
        4: begin cfg_write(3'd0, 32'd127); cfg_write(3'd4, 32'd6000); end
        default: begin cfg_write(3'd0, 32'd20); cfg_write(3'd4, 32'd65536); end
      endcase
      sender_idle = ph < 2 ? 24 : (ph < 4 ? 70 : 0);
      for (int i = 0; i < 200; i++) random_item();
      settle();
    end

    $display("covered %0d ok, %0d oversize, %0d out-of-memory transactions", n_ok, n_big,
             n_oom);
    $display("over six register settings from minimum refill to exhausted heap");
    if (errors == 0 && pending.size() == 0) begin
      $display("segregated_free_list_allocator: match");
    end else begin
      $display("segregated_free_list_allocator: mismatch");
    end
    $finish;
  end

endmodule
